[rtl/lslh_pkg.sv]
package lslh_pkg;

    localparam int FRAME_BYTES = 40;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);

    localparam logic [7:0] SRC_MODULE = 8'hA0;
    localparam logic [7:0] SRC_LOCK   = 8'hB0;
    localparam logic [7:0] SRC_LOCK1  = 8'hB1;
    localparam logic [7:0] SRC_REPLY  = 8'hA1;

    localparam logic [7:0] CMD_STATUS = 8'h11;
    localparam logic [7:0] CMD_LOCK   = 8'h10;
    localparam logic [7:0] CMD_EVENT  = 8'h30;
    localparam logic [7:0] CMD_ACK    = 8'h33;
    localparam logic [7:0] CMD_INFO   = 8'h37;
    localparam logic [7:0] CMD_DISC   = 8'h44;

    localparam logic [7:0] EV_JAM      = 8'h09;
    localparam logic [7:0] EV_PIN      = 8'h13;
    localparam logic [7:0] EV_USER     = 8'h15;
    localparam logic [7:0] EV_SELF_L   = 8'h18;
    localparam logic [7:0] EV_SELF_U   = 8'h19;
    localparam logic [7:0] EV_TIMEOUT  = 8'h1B;
    localparam logic [7:0] EV_NFC      = 8'h90;
    localparam logic [7:0] EV_LOW_BATT = 8'hA7;

    localparam logic [19:0] IDLE_MAX   = 20'hFFFFF;
    localparam logic [19:0] IDLE_RST   = 20'd10000;
    localparam logic [31:0] STAT_RST   = 32'd1800000000;

    typedef enum logic [1:0] {OP_BYTE = 2'd0, OP_TICK = 2'd1, OP_CMD = 2'd2} op_t;

    typedef enum logic [2:0] {
        K_TX = 3'd0, K_STATUS = 3'd1, K_EVENT = 3'd2, K_BATT = 3'd3, K_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        E_OVERFLOW = 3'd0, E_SHORT = 3'd1, E_CHECKSUM = 3'd2, E_SIZE = 3'd3,
        E_SOURCE = 3'd4, E_EVENT = 3'd5, E_COMMAND = 3'd6
    } err_t;

    typedef enum logic [1:0] {LS_LOCKED = 2'd0, LS_UNLOCKED = 2'd1, LS_JAMMED = 2'd2} lstate_t;

    typedef enum logic [2:0] {
        ES_NONE = 3'd0, ES_PIN = 3'd1, ES_USER = 3'd2, ES_SELF = 3'd3,
        ES_TIMEOUT = 3'd4, ES_NFC = 3'd5
    } esrc_t;

    localparam int CFG_IDLE = 0;
    localparam int CFG_STAT = 1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic [1:0] lock_state;
        logic [2:0] event_source;
        logic [7:0] slot;
        logic [2:0] error_code;
    } res_t;

    function automatic res_t report(kind_t k, lstate_t ls, esrc_t es, logic [7:0] sl,
                                    err_t e);
        res_t r;
        r.kind         = k;
        r.tx_byte      = 8'h00;
        r.last_byte    = 1'b0;
        r.lock_state   = ls;
        r.event_source = es;
        r.slot         = sl;
        r.error_code   = e;
        return r;
    endfunction

endpackage

[rtl/lslh_ram.sv]
module lslh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/lock_serial_link_handler.sv]
// Serial link handler for a smart lock.
// Input channel s_*: one item per handshake. s_tuser carries the op: a byte
// received from the lock, one time tick, or a lock/unlock request. Received
// bytes are written into a 40-entry frame RAM.
// Output channel m_*: one result item per handshake: a transmit byte (m_tlast
// on the final byte of an outgoing frame) or a status, lock event, low
// battery or error report.
// Flow: a byte or an ignored op is taken in S_IDLE, a plain tick also passes S_STAT. A tick that closes
// a frame walks the frame RAM one entry a cycle, read pipelined behind the
// address, then passes S_DRAIN and S_CHECK before any result items. An
// outgoing frame goes out one byte per cycle while m_tready allows (5 or 6 bytes). The
// frame RAM has a separate write and read port; the block holds one item at a time.
// s_tready is low while an item still has results to deliver.
// Receiver stall: m_tvalid holds with its data until m_tready; the sequencer
// waits before loading the next result, so nothing is dropped.
// Reset (rst_n low, async): counters, frame length and the discovered flag
// clear, registers take their defaults; the RAM is not cleared and needs no
// clearing pass.
// Configuration: cfg_we with cfg_index 0 (idle timeout) or 1 (status interval).
module lock_serial_link_handler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], want_unlock[8], zero fill
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tx_byte, lock_state, event_source, slot, error_code
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast,   // last_byte
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import lslh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DRAIN, S_CHECK, S_REPORT, S_SEND, S_STAT
    } state_t;

    state_t            state_reg;
    logic [19:0]       idle_to_reg;
    logic [31:0]       stat_iv_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W-1:0] flen_reg;
    logic [19:0]       idle_cnt_reg;
    logic [31:0]       stat_cnt_reg;
    logic              found_reg;
    logic              chk_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] last_reg;
    logic              rd_v_reg;
    logic [ADDR_W-1:0] rd_i_reg;
    logic [7:0]        xor_reg;
    logic [7:0]        hdr_reg [6];
    res_t              res_reg;
    logic [7:0]        f_cmd_reg, f_src_reg, f_cnt_reg, f_pay_reg, f_x_reg;
    logic              f_size_reg;
    logic [2:0]        idx_reg;
    logic              m_v_reg;
    res_t              m_reg;

    logic              accept, can_load, out_load, ram_we, ram_re;
    logic [7:0]        rdata, sbyte;
    logic [2:0]        f_last;
    logic [19:0]       idle_inc;
    logic [31:0]       stat_inc;
    logic [8:0]        want_len;
    res_t              tx_res;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_load = !m_v_reg || m_tready;
    assign out_load = can_load && (state_reg == S_REPORT || state_reg == S_SEND);
    assign ram_we   = accept && (s_tuser == OP_BYTE);
    assign ram_re   = (state_reg == S_WALK);
    assign idle_inc = (idle_cnt_reg == IDLE_MAX) ? idle_cnt_reg : idle_cnt_reg + 20'd1;
    assign stat_inc = (stat_cnt_reg == '1) ? stat_cnt_reg : stat_cnt_reg + 32'd1;
    assign f_last   = {2'b10, f_size_reg};
    assign want_len = {1'b0, hdr_reg[3]} + 9'd5;

    always_comb
    begin
        case (idx_reg)
            3'd0:    sbyte = f_cmd_reg;
            3'd1:    sbyte = f_src_reg;
            3'd2:    sbyte = f_cnt_reg;
            3'd3:    sbyte = {7'd0, f_size_reg};
            default: sbyte = f_pay_reg;
        endcase
        if (idx_reg == f_last)
        begin
            sbyte = f_x_reg;
        end
    end

    // transmit item for the current frame byte
    always_comb
    begin
        tx_res           = report(K_TX, LS_LOCKED, ES_NONE, 8'h00, E_OVERFLOW);
        tx_res.tx_byte   = sbyte;
        tx_res.last_byte = (idx_reg == f_last);
    end

    lslh_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg),
        .wdata (s_tdata[7:0]),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idle_to_reg  <= IDLE_RST;
            stat_iv_reg  <= STAT_RST;
            len_reg      <= '0;
            idle_cnt_reg <= '0;
            stat_cnt_reg <= '0;
            found_reg    <= 1'b0;
            chk_reg      <= 1'b0;
            rd_v_reg     <= 1'b0;
            m_v_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == 1'(CFG_IDLE))
                    idle_to_reg <= cfg_data[19:0];
                else
                    stat_iv_reg <= cfg_data;
            end
            if (m_v_reg && m_tready && !out_load)
                m_v_reg <= 1'b0;

            // read pipeline: data for rd_i_reg lands in the cycle after its address
            rd_v_reg <= ram_re;
            rd_i_reg <= addr_reg;
            if (rd_v_reg)
            begin
                if (rd_i_reg < flen_reg)
                    xor_reg <= xor_reg ^ rdata;
                if (rd_i_reg < ADDR_W'(6))
                    hdr_reg[rd_i_reg[2:0]] <= rdata;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        chk_reg <= (s_tuser == OP_TICK);
                        unique case (s_tuser)
                            OP_BYTE:
                            begin
                                if (len_reg == ADDR_W'(FRAME_BYTES - 1))
                                begin
                                    len_reg   <= '0;
                                    res_reg   <= report(K_ERROR, LS_LOCKED, ES_NONE, 8'h00,
                                                        E_OVERFLOW);
                                    state_reg <= S_REPORT;
                                end
                                else
                                begin
                                    len_reg      <= len_reg + ADDR_W'(1);
                                    idle_cnt_reg <= '0;
                                end
                            end
                            OP_TICK:
                            begin
                                idle_cnt_reg <= idle_inc;
                                stat_cnt_reg <= stat_inc;
                                if (len_reg != '0 && idle_inc > idle_to_reg)
                                begin
                                    len_reg  <= '0;
                                    flen_reg <= len_reg;
                                    if (len_reg < ADDR_W'(5))
                                    begin
                                        res_reg   <= report(K_ERROR, LS_LOCKED, ES_NONE,
                                                            8'h00, E_SHORT);
                                        state_reg <= S_REPORT;
                                    end
                                    else
                                    begin
                                        // walk at least through entry 5 for the slot
                                        addr_reg  <= '0;
                                        last_reg  <= (len_reg > ADDR_W'(6)) ?
                                                     len_reg - ADDR_W'(1) : ADDR_W'(5);
                                        xor_reg   <= 8'h00;
                                        state_reg <= S_WALK;
                                    end
                                end
                                else
                                begin
                                    state_reg <= S_STAT;
                                end
                            end
                            OP_CMD:
                            begin
                                f_cmd_reg  <= CMD_LOCK;
                                f_src_reg  <= SRC_MODULE;
                                f_cnt_reg  <= 8'h00;
                                f_size_reg <= 1'b1;
                                f_pay_reg  <= s_tdata[8] ? 8'h00 : 8'hFF;
                                f_x_reg    <= 8'h00;
                                idx_reg    <= '0;
                                state_reg  <= S_SEND;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    if (addr_reg == last_reg)
                        state_reg <= S_DRAIN;
                    else
                        addr_reg <= addr_reg + ADDR_W'(1);
                end
                S_DRAIN:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (xor_reg != 8'h00)
                    begin
                        res_reg   <= report(K_ERROR, LS_LOCKED, ES_NONE, 8'h00, E_CHECKSUM);
                        state_reg <= S_REPORT;
                    end
                    else if ({3'd0, flen_reg} != want_len)
                    begin
                        res_reg   <= report(K_ERROR, LS_LOCKED, ES_NONE, 8'h00, E_SIZE);
                        state_reg <= S_REPORT;
                    end
                    else if (hdr_reg[1] != SRC_LOCK &&
                             !(hdr_reg[1] == SRC_LOCK1 && hdr_reg[0] == CMD_STATUS))
                    begin
                        res_reg   <= report(K_ERROR, LS_LOCKED, ES_NONE, 8'h00, E_SOURCE);
                        state_reg <= S_REPORT;
                    end
                    else
                    begin
                        found_reg <= 1'b1;
                        case (hdr_reg[0])
                            CMD_STATUS:
                            begin
                                if (hdr_reg[4] == 8'hFF)
                                begin
                                    res_reg   <= report(K_STATUS, LS_LOCKED, ES_NONE, 8'h00,
                                                        E_OVERFLOW);
                                    state_reg <= S_REPORT;
                                end
                                else if (hdr_reg[4] == 8'h00)
                                begin
                                    res_reg   <= report(K_STATUS, LS_UNLOCKED, ES_NONE, 8'h00,
                                                        E_OVERFLOW);
                                    state_reg <= S_REPORT;
                                end
                                else
                                    state_reg <= S_STAT;
                            end
                            CMD_EVENT:
                            begin
                                state_reg <= S_REPORT;
                                case (hdr_reg[4])
                                    EV_JAM:      res_reg <= report(K_EVENT, LS_JAMMED,
                                                     ES_NONE, 8'h00, E_OVERFLOW);
                                    EV_PIN:      res_reg <= report(K_EVENT, LS_UNLOCKED,
                                                     ES_PIN, hdr_reg[5], E_OVERFLOW);
                                    EV_USER:     res_reg <= report(K_EVENT, LS_LOCKED,
                                                     ES_USER, 8'h00, E_OVERFLOW);
                                    EV_SELF_L:   res_reg <= report(K_EVENT, LS_LOCKED,
                                                     ES_SELF, 8'h00, E_OVERFLOW);
                                    EV_SELF_U:   res_reg <= report(K_EVENT, LS_UNLOCKED,
                                                     ES_SELF, 8'h00, E_OVERFLOW);
                                    EV_TIMEOUT:  res_reg <= report(K_EVENT, LS_LOCKED,
                                                     ES_TIMEOUT, 8'h00, E_OVERFLOW);
                                    EV_NFC:      res_reg <= report(K_EVENT, LS_UNLOCKED,
                                                     ES_NFC, hdr_reg[5], E_OVERFLOW);
                                    EV_LOW_BATT: res_reg <= report(K_BATT, LS_LOCKED,
                                                     ES_NONE, 8'h00, E_OVERFLOW);
                                    default:     res_reg <= report(K_ERROR, LS_LOCKED,
                                                     ES_NONE, 8'h00, E_EVENT);
                                endcase
                            end
                            CMD_ACK, CMD_DISC:
                            begin
                                f_cmd_reg  <= hdr_reg[0];
                                f_src_reg  <= SRC_REPLY;
                                f_cnt_reg  <= hdr_reg[2];
                                f_size_reg <= (hdr_reg[0] == CMD_DISC);
                                f_pay_reg  <= 8'h00;
                                f_x_reg    <= 8'h00;
                                idx_reg    <= '0;
                                state_reg  <= S_SEND;
                                if (hdr_reg[0] == CMD_DISC)
                                    stat_cnt_reg <= '1;
                            end
                            CMD_INFO:
                            begin
                                state_reg <= S_STAT;
                            end
                            default:
                            begin
                                res_reg   <= report(K_ERROR, LS_LOCKED, ES_NONE, 8'h00,
                                                    E_COMMAND);
                                state_reg <= S_REPORT;
                            end
                        endcase
                    end
                end
                S_REPORT:
                begin
                    if (can_load)
                    begin
                        m_v_reg   <= 1'b1;
                        m_reg     <= res_reg;
                        state_reg <= chk_reg ? S_STAT : S_IDLE;
                    end
                end
                S_SEND:
                begin
                    if (can_load)
                    begin
                        m_v_reg <= 1'b1;
                        m_reg   <= tx_res;
                        f_x_reg <= f_x_reg ^ sbyte;
                        if (idx_reg == f_last)
                            state_reg <= chk_reg ? S_STAT : S_IDLE;
                        else
                            idx_reg <= idx_reg + 3'd1;
                    end
                end
                S_STAT:
                begin
                    chk_reg <= 1'b0;
                    if (found_reg && stat_cnt_reg > stat_iv_reg)
                    begin
                        stat_cnt_reg <= '0;
                        f_cmd_reg    <= CMD_STATUS;
                        f_src_reg    <= SRC_MODULE;
                        f_cnt_reg    <= 8'h00;
                        f_size_reg   <= 1'b0;
                        f_pay_reg    <= 8'h00;
                        f_x_reg      <= 8'h00;
                        idx_reg      <= '0;
                        state_reg    <= S_SEND;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tuser  = m_reg.kind;
    assign m_tlast  = m_reg.last_byte;
    assign m_tdata  = {m_reg.error_code, m_reg.slot, m_reg.event_source,
                       m_reg.lock_state, m_reg.tx_byte};

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg < ADDR_W'(FRAME_BYTES))
        else $error("frame length out of range");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == OP_BYTE && len_reg == ADDR_W'(FRAME_BYTES - 1))
        |=> (state_reg == S_REPORT && len_reg == '0))
        else $error("overflow not reported");

    a_send_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |-> (idx_reg <= f_last))
        else $error("send index past frame end");

    a_no_load_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_v_reg && !m_tready) |=> m_v_reg)
        else $error("result dropped under stall");

endmodule
